[design/nsuv_pkg.sv]
// Shared types, widths and constants for the normal to sphere UV mapper.
// Used by nsuv_isqrt, nsuv_atan2 and normal_to_sphere_uv; depends on nothing.
package nsuv_pkg;

    localparam int ANG_W       = 34;  // angle and CORDIC datapath width
    localparam int DIV_STAGES  = 32;  // quotient bits of the residual correction
    localparam int ISQ_BITS    = 29;  // root bits of the square root unit
    localparam int REM_W       = 58;  // square root remainder width
    localparam int TABLE_LEN   = 24;
    localparam int IN_W        = 16;
    localparam int OUT_W       = 17;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 40;

    localparam logic [29:0] TURN_PER_RAD = 30'd683565276;
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic [28:0] ONE_SQ = 29'd268435456;  // 1.0 squared in Q1.28

    typedef logic signed [ANG_W-1:0] t_ang;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [29:0] step_angle(input int unsigned idx);
        logic [29:0] a;
        case (idx)
            0:       a = 30'd536870912;
            1:       a = 30'd316933406;
            2:       a = 30'd167458907;
            3:       a = 30'd85004756;
            4:       a = 30'd42667331;
            5:       a = 30'd21354465;
            6:       a = 30'd10679838;
            7:       a = 30'd5340245;
            8:       a = 30'd2670163;
            9:       a = 30'd1335087;
            10:      a = 30'd667544;
            11:      a = 30'd333772;
            12:      a = 30'd166886;
            13:      a = 30'd83443;
            14:      a = 30'd41722;
            15:      a = 30'd20861;
            16:      a = 30'd10430;
            17:      a = 30'd5215;
            18:      a = 30'd2608;
            19:      a = 30'd1304;
            20:      a = 30'd652;
            21:      a = 30'd326;
            22:      a = 30'd163;
            23:      a = 30'd81;
            default: a = 30'd0;
        endcase
        return a;
    endfunction

endpackage

[design/nsuv_isqrt.sv]
// Pipelined integer square root of (i_rad << 28), one root bit per stage.
// Depends on nsuv_pkg; every stage advances only on i_en.
module nsuv_isqrt (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [28:0]                   i_rad,
    output logic [nsuv_pkg::ISQ_BITS-1:0] o_root
);

    localparam int NB = nsuv_pkg::ISQ_BITS;
    localparam int RW = nsuv_pkg::REM_W;

    logic [RW-1:0] r_rem  [NB];
    logic [NB-1:0] r_root [NB];

    for (genvar k = 0; k < NB; k++) begin : g_stage
        localparam int B = NB - 1 - k;
        logic [RW-1:0] s_rem;
        logic [NB-1:0] s_root;
        logic [RW-1:0] trial;

        if (k == 0) begin : g_first
            assign s_rem  = {1'b0, i_rad, 28'd0};
            assign s_root = '0;
        end else begin : g_next
            assign s_rem  = r_rem[k-1];
            assign s_root = r_root[k-1];
        end

        // (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B)
        assign trial = ({{(RW-NB){1'b0}}, s_root} << (B + 1)) + (RW'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (s_rem >= trial) begin
                    r_rem[k]  <= s_rem - trial;
                    r_root[k] <= s_root | (NB'(1) << B);
                end else begin
                    r_rem[k]  <= s_rem;
                    r_root[k] <= s_root;
                end
            end
        end
    end

    assign o_root = r_root[NB-1];

endmodule

[design/nsuv_atan2.sv]
// Pipelined atan2 in units of 2^-32 turn: vectoring CORDIC, then a residual
// correction y*K/x through a restoring divider. Depends on nsuv_pkg.
module nsuv_atan2 #(
    parameter int STEPS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  nsuv_pkg::t_ang       i_y,
    input  nsuv_pkg::t_ang       i_x,
    output nsuv_pkg::t_ang       o_ang
);

    localparam int W  = nsuv_pkg::ANG_W;
    localparam int DS = nsuv_pkg::DIV_STAGES;

    // Pre-rotation into the right half plane.
    nsuv_pkg::t_ang r_px, r_py, r_pacc;
    logic           r_pz;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pz <= (i_x == '0) && (i_y == '0);
            if (i_x[W-1] && !i_y[W-1]) begin
                r_px   <= i_y;
                r_py   <= -i_x;
                r_pacc <= nsuv_pkg::QUARTER_TURN;
            end else if (i_x[W-1]) begin
                r_px   <= -i_y;
                r_py   <= i_x;
                r_pacc <= -nsuv_pkg::QUARTER_TURN;
            end else begin
                r_px   <= i_x;
                r_py   <= i_y;
                r_pacc <= '0;
            end
        end
    end

    nsuv_pkg::t_ang r_cx [STEPS];
    nsuv_pkg::t_ang r_cy [STEPS];
    nsuv_pkg::t_ang r_cacc [STEPS];
    logic           r_cz [STEPS];

    for (genvar i = 0; i < STEPS; i++) begin : g_cordic
        localparam nsuv_pkg::t_ang ANG = {4'd0, nsuv_pkg::step_angle(i)};
        nsuv_pkg::t_ang sx, sy, sacc;
        logic           sz;

        if (i == 0) begin : g_first
            assign sx = r_px;
            assign sy = r_py;
            assign sacc = r_pacc;
            assign sz = r_pz;
        end else begin : g_next
            assign sx = r_cx[i-1];
            assign sy = r_cy[i-1];
            assign sacc = r_cacc[i-1];
            assign sz = r_cz[i-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_cz[i] <= sz;
                if (!sy[W-1]) begin
                    r_cx[i]   <= sx + (sy >>> i);
                    r_cy[i]   <= sy - (sx >>> i);
                    r_cacc[i] <= sacc + ANG;
                end else begin
                    r_cx[i]   <= sx - (sy >>> i);
                    r_cy[i]   <= sy + (sx >>> i);
                    r_cacc[i] <= sacc - ANG;
                end
            end
        end
    end

    // Residual magnitude times radians-to-turns factor.
    logic [63:0]    r_mmag;
    logic           r_msgn, r_mz;
    logic [31:0]    r_mx;
    nsuv_pkg::t_ang r_macc;
    logic [W-1:0]   ymag;

    assign ymag = r_cy[STEPS-1][W-1] ? W'(-r_cy[STEPS-1]) : W'(r_cy[STEPS-1]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mmag <= 64'(ymag * nsuv_pkg::TURN_PER_RAD);
            r_msgn <= r_cy[STEPS-1][W-1];
            r_mx   <= r_cx[STEPS-1][31:0];
            r_macc <= r_cacc[STEPS-1];
            r_mz   <= r_cz[STEPS-1];
        end
    end

    logic [31:0]    r_drem [DS];
    logic [31:0]    r_dq   [DS];
    logic [31:0]    r_dlow [DS];
    logic [31:0]    r_dx   [DS];
    logic           r_dsgn [DS];
    logic           r_dz   [DS];
    nsuv_pkg::t_ang r_dacc [DS];

    for (genvar j = 0; j < DS; j++) begin : g_div
        logic [31:0]    srem, sq, slow, sx;
        logic           ssgn, sz;
        nsuv_pkg::t_ang sacc;
        logic [32:0]    t;
        logic           ge;

        if (j == 0) begin : g_first
            assign srem = r_mmag[63:32];
            assign sq   = '0;
            assign slow = r_mmag[31:0];
            assign sx   = r_mx;
            assign ssgn = r_msgn;
            assign sz   = r_mz;
            assign sacc = r_macc;
        end else begin : g_next
            assign srem = r_drem[j-1];
            assign sq   = r_dq[j-1];
            assign slow = r_dlow[j-1];
            assign sx   = r_dx[j-1];
            assign ssgn = r_dsgn[j-1];
            assign sz   = r_dz[j-1];
            assign sacc = r_dacc[j-1];
        end

        assign t  = {srem, slow[DS-1-j]};
        assign ge = t >= {1'b0, sx};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_drem[j] <= ge ? 32'(t - {1'b0, sx}) : t[31:0];
                r_dq[j]   <= {sq[30:0], ge};
                r_dlow[j] <= slow;
                r_dx[j]   <= sx;
                r_dsgn[j] <= ssgn;
                r_dz[j]   <= sz;
                r_dacc[j] <= sacc;
            end
        end
    end

    nsuv_pkg::t_ang r_ang;
    nsuv_pkg::t_ang qs;

    assign qs = r_dsgn[DS-1] ? -{2'b00, r_dq[DS-1]} : {2'b00, r_dq[DS-1]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang <= r_dz[DS-1] ? '0 : r_dacc[DS-1] + qs;
        end
    end

    assign o_ang = r_ang;

endmodule

[design/normal_to_sphere_uv.sv]
// Top level of the normal to equirectangular UV mapper.
// Depends on nsuv_pkg, nsuv_isqrt and nsuv_atan2.

// Takes one unit normal per cycle and returns u = (atan2(nz,nx)+pi)/(2pi) and
// v = acos(ny)/pi as unsigned Q1.16 (0..65536). Throughput is one transaction
// per cycle while the output is not stalled; the path runs through the 29-stage
// square root, the ANGLE_STEPS CORDIC stages and the 32-stage residual divider.
// The whole pipeline advances together and holds while a result waits at the output.
module normal_to_sphere_uv #(
    parameter int ANGLE_STEPS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [nsuv_pkg::S_TDATA_W-1:0]    i_s_tdata,  // nx[15:0], ny[31:16], nz[47:32]
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [nsuv_pkg::M_TDATA_W-1:0]    o_m_tdata   // u_coord[16:0], v_coord[33:17], zeros
);

    localparam int DLY = nsuv_pkg::ISQ_BITS + 1;
    localparam int LAT = 1 + DLY + ANGLE_STEPS + 35 + 1;

    logic en;
    logic [LAT-1:0] r_vld;

    assign en         = !r_vld[LAT-1] || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_tvalid};
        end
    end

    // Input stage with ny saturated to plus or minus one.
    logic signed [15:0] in_nx, in_ny, in_nz, nyc;
    logic signed [15:0] r_nx, r_nyc, r_nz;

    assign in_nx = i_s_tdata[15:0];
    assign in_ny = i_s_tdata[31:16];
    assign in_nz = i_s_tdata[47:32];
    assign nyc   = (in_ny > 16'sd16384) ? 16'sd16384 :
                   (in_ny < -16'sd16384) ? -16'sd16384 : in_ny;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nx  <= in_nx;
            r_nyc <= nyc;
            r_nz  <= in_nz;
        end
    end

    logic [28:0] r_rad;
    logic signed [31:0] ny_sq;

    assign ny_sq = r_nyc * r_nyc;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rad <= nsuv_pkg::ONE_SQ - ny_sq[28:0];
        end
    end

    logic [nsuv_pkg::ISQ_BITS-1:0] root;

    nsuv_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_rad),
        .o_root (root)
    );

    // Components wait here while the square root runs.
    logic signed [15:0] r_dnx [DLY];
    logic signed [15:0] r_dny [DLY];
    logic signed [15:0] r_dnz [DLY];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dnx[0] <= r_nx;
            r_dny[0] <= r_nyc;
            r_dnz[0] <= r_nz;
            for (int k = 1; k < DLY; k++) begin
                r_dnx[k] <= r_dnx[k-1];
                r_dny[k] <= r_dny[k-1];
                r_dnz[k] <= r_dnz[k-1];
            end
        end
    end

    nsuv_pkg::t_ang u_y, u_x, v_y, v_x, az, pol;

    assign u_y = {{4{r_dnz[DLY-1][15]}}, r_dnz[DLY-1], 14'd0};
    assign u_x = {{4{r_dnx[DLY-1][15]}}, r_dnx[DLY-1], 14'd0};
    assign v_y = {5'd0, root};
    assign v_x = {{4{r_dny[DLY-1][15]}}, r_dny[DLY-1], 14'd0};

    nsuv_atan2 #(.STEPS(ANGLE_STEPS)) u_atan_u (
        .i_clk (i_clk),
        .i_en  (en),
        .i_y   (u_y),
        .i_x   (u_x),
        .o_ang (az)
    );

    nsuv_atan2 #(.STEPS(ANGLE_STEPS)) u_atan_v (
        .i_clk (i_clk),
        .i_en  (en),
        .i_y   (v_y),
        .i_x   (v_x),
        .o_ang (pol)
    );

    logic signed [35:0] usum, vsum, ushf, vshf;
    logic [16:0] uc, vc;
    logic [16:0] r_u, r_v;

    assign usum = 36'(az) + 36'sd2147483648 + 36'sd32768;
    assign vsum = 36'(pol) + 36'sd16384;
    assign ushf = usum >>> 16;
    assign vshf = vsum >>> 15;
    assign uc = ushf[35] ? 17'd0 : (ushf > 36'sd65536) ? 17'd65536 : ushf[16:0];
    assign vc = vshf[35] ? 17'd0 : (vshf > 36'sd65536) ? 17'd65536 : vshf[16:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u <= uc;
            r_v <= vc;
        end
    end

    assign o_m_tdata = {6'd0, r_v, r_u};

`ifndef SYNTHESIS
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_u <= 17'd65536) && (r_v <= 17'd65536))
        else $error("coordinate out of range");

    a_accept_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_vld[0])
        else $error("accepted transaction not tracked");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline moved during stall");
`endif

endmodule

[sim/nsuv_checker.sv]
// Checker for normal_to_sphere_uv: watches both stream channels, predicts UV per accepted normal.
// Depends on nsuv_pkg for the bus widths; holds its own fixed-point arctangent and square root.
`timescale 1ns / 100ps

module nsuv_checker #(
    parameter int ANGLE_STEPS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [nsuv_pkg::S_TDATA_W-1:0] i_s_tdata,  // nx[15:0], ny[31:16], nz[47:32]
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [nsuv_pkg::M_TDATA_W-1:0] i_m_tdata,  // u_coord[16:0], v_coord[33:17], zeros
    output int                             o_errors,
    output int                             o_pending,
    output int                             o_results
);

    localparam longint QUARTER = 64'sd1073741824;
    localparam longint HALF    = 64'sd2147483648;
    localparam longint RAD2TRN = 64'sd683565276;
    localparam longint UNIT    = 64'sd16384;

    // Arctangent of 2^-i, 2^-32 turn units.
    localparam longint MICRO_ANGLE [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    typedef struct packed {
        logic [16:0] u_coord;
        logic [16:0] v_coord;
    } uv_t;

    uv_t uv_expected[$];

    function automatic longint atan2_turns(longint y, longint x);
        longint acc;
        longint t;
        longint dx;
        longint dy;
        acc = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; acc = QUARTER;
            end else begin
                x = -y; y = t; acc = -QUARTER;
            end
        end
        for (int i = 0; i < ANGLE_STEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; acc += MICRO_ANGLE[i];
            end else begin
                x -= dx; y += dy; acc -= MICRO_ANGLE[i];
            end
        end
        // Linear finish on the leftover angle, truncating toward zero.
        if (x > 0) acc += (y * RAD2TRN) / x;
        return acc;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= root + b) begin
                n -= root + b;
                root = (root >> 1) + b;
            end else begin
                root >>= 1;
            end
            b >>= 2;
        end
        return root;
    endfunction

    function automatic logic [16:0] clamp_q16(longint v);
        if (v < 0) return 17'd0;
        if (v > 65536) return 17'd65536;
        return v[16:0];
    endfunction

    function automatic uv_t map_normal(logic [nsuv_pkg::S_TDATA_W-1:0] d);
        longint nx;
        longint ny;
        longint nz;
        longint sine;
        uv_t r;
        nx = longint'($signed(d[15:0]));
        ny = longint'($signed(d[31:16]));
        nz = longint'($signed(d[47:32]));
        r.u_coord = clamp_q16((atan2_turns(nz * UNIT, nx * UNIT) + HALF + 32768) >>> 16);
        if (ny > UNIT) ny = UNIT;
        if (ny < -UNIT) ny = -UNIT;
        sine = longint'(int_sqrt(longint'(UNIT * UNIT - ny * ny) << 28));
        r.v_coord = clamp_q16((atan2_turns(sine, ny * UNIT) + 16384) >>> 15);
        return r;
    endfunction

    always @(posedge i_clk) begin
        uv_t want;
        uv_t got;
        if (!i_rst_n) begin
            uv_expected.delete();
            o_errors  <= 0;
            o_results <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready) uv_expected.push_back(map_normal(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got.u_coord = i_m_tdata[16:0];
                got.v_coord = i_m_tdata[33:17];
                o_results <= o_results + 1;
                if (uv_expected.size() == 0) begin
                    if (o_errors < 10) $display("%0t: result with no transaction pending", $time);
                    o_errors <= o_errors + 1;
                end else begin
                    want = uv_expected.pop_front();
                    if (want != got || i_m_tdata[39:34] != 0) begin
                        if (o_errors < 10)
                            $display("%0t: uv mismatch exp u=%0d v=%0d got u=%0d v=%0d pad=%h",
                                     $time, want.u_coord, want.v_coord, got.u_coord,
                                     got.v_coord, i_m_tdata[39:34]);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= uv_expected.size();
    end

endmodule

[sim/tb_normal_to_sphere_uv.sv]
// Top of the normal_to_sphere_uv testbench: clock, reset, stimulus and verdict.
// Depends on nsuv_pkg, the block under test and nsuv_checker.
`timescale 1ns / 100ps

module tb_normal_to_sphere_uv;

    localparam int ANGLE_STEPS = 16;
    localparam int LATENCY     = ANGLE_STEPS + 67;
    localparam int N_RANDOM    = 1530;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [nsuv_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [nsuv_pkg::M_TDATA_W-1:0] m_tdata;
    int                             errors;
    int                             pending;
    int                             results;
    int                             gap_pct = 0;
    int                             stall_pct = 0;
    int                             sent = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    normal_to_sphere_uv #(.ANGLE_STEPS(ANGLE_STEPS)) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    nsuv_checker #(.ANGLE_STEPS(ANGLE_STEPS)) u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_results  (results)
    );

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Holds one normal on the bus until its transaction completes, then maybe idles.
    // Each following cycle idles with probability gap_pct, until the first draw that does not.
    task automatic send_normal(logic [15:0] nx, logic [15:0] ny, logic [15:0] nz);
        s_tvalid <= 1'b1;
        s_tdata  <= {nz, ny, nx};
        do @(posedge i_clk); while (!s_tready);
        sent++;
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {16'($urandom), $urandom};
            @(posedge i_clk);
        end
    endtask

    function automatic logic [15:0] pick_component(int mode);
        int r;
        r = $urandom_range(99);
        if (mode < 60) return 16'($signed($urandom_range(32768)) - 16384);
        if (mode < 80) return 16'($urandom);
        case (r % 8)
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'd0;
            3: return 16'sd32767;
            4: return 16'h8000;
            5: return 16'($signed($urandom_range(2)) - 1);
            6: return 16'($urandom_range(16384, 16300));
            default: return -16'($urandom_range(16384, 16300));
        endcase
    endfunction

    task automatic send_random();
        int mode;
        int c;
        logic [15:0] f[3];
        mode = $urandom_range(99);
        for (int k = 0; k < 3; k++) f[k] = pick_component(mode);
        // Some items get one zero component so that zero and sign boundaries recur with noise around them.
        if ($urandom_range(9) == 0) begin
            c = $urandom_range(2);
            f[c] = 16'd0;
        end
        send_normal(f[0], f[1], f[2]);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Axes, zero vector, zero azimuth, negative x axis, ny beyond one, raw extremes, diagonals.
        send_normal(16'sd16384, 16'sd0, 16'sd0);
        send_normal(-16'sd16384, 16'sd0, 16'sd0);
        send_normal(16'sd0, 16'sd0, 16'sd16384);
        send_normal(16'sd0, 16'sd0, -16'sd16384);
        send_normal(16'sd0, 16'sd16384, 16'sd0);
        send_normal(16'sd0, -16'sd16384, 16'sd0);
        send_normal(16'sd0, 16'sd0, 16'sd0);
        send_normal(-16'sd5, 16'sd100, 16'sd0);
        send_normal(-16'sd1, 16'sd0, 16'sd0);
        send_normal(16'sd0, 16'sd32767, 16'sd0);
        send_normal(16'sd0, 16'h8000, 16'sd0);
        send_normal(16'sd1, 16'sd16385, -16'sd1);
        send_normal(16'sd1, -16'sd16385, 16'sd1);
        send_normal(16'sd32767, 16'sd0, 16'sd32767);
        send_normal(16'h8000, 16'sd0, 16'h8000);
        send_normal(16'h8000, 16'sd0, 16'sd32767);
        send_normal(16'sd32767, 16'sd0, 16'h8000);
        send_normal(-16'sd16384, 16'sd0, -16'sd1);
        send_normal(-16'sd16384, 16'sd0, 16'sd1);
        send_normal(16'sd11585, 16'sd11585, 16'sd0);
        send_normal(-16'sd9459, -16'sd9459, -16'sd9459);
        send_normal(16'hFFFF, 16'hFFFF, 16'hFFFF);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 56; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 56; end
                default: begin gap_pct = 34; stall_pct = 34; end
            endcase
            repeat (N_RANDOM / 4) send_random();
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);

        $display("Sent %0d normals (axes, degenerate and out-of-range components,", sent);
        $display("random directions) under four handshake idle/stall mixes;");
        $display("%0d UV results checked, %0d failures.", results, errors);
        if (errors == 0 && pending == 0) begin
            $display("normal_to_sphere_uv regression: pass");
        end else begin
            $display("normal_to_sphere_uv regression: fail");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("normal_to_sphere_uv regression: fail");
        $finish;
    end

endmodule
